/* sv/vptw_pkg.sv */
package vptw_pkg;

	localparam int FRAC_BITS_DEF  = 16;
	localparam int STORE_DEPTH    = 32;
	localparam int PROJ_BASE      = 16;
	localparam int FIFO_DEPTH_DEF = 4;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 13;

	typedef enum logic {
		MODE_LOAD    = 1'b0,
		MODE_PROJECT = 1'b1
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT   = 2'd0,
		CFG_BOTTOM = 2'd1,
		CFG_SPAN_X = 2'd2,
		CFG_SPAN_Y = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	typedef struct packed {
		logic [11:0] left;
		logic [11:0] bottom;
		logic [12:0] span_x;
		logic [12:0] span_y;
	} viewport_t;

endpackage

/* sv/vertex_project_to_window_unit.sv */
// channel | direction | handshake           | payload
// in      | to block  | in_valid/in_ready   | mode, coef_index, coef_value, point_x/y/z
// out     | from block| out_valid/out_ready | win_x, win_y, zero_w, saturated
// cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One projection per cycle while the output is not stalled; points pass through the
// matrix stages, the bit-per-stage divider and the viewport stages.
// A load waits until the queue and the three eye-space stages are empty.
// Reset clears valids and sets the viewport to left 0, bottom 0, 640 x 480; coefficients hold no reset.
// A stalled output freezes the back pipeline; a FIFO_DEPTH-entry queue (4 by default) keeps taking points.
module vertex_project_to_window_unit import vptw_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [4:0]            coef_index,
	input  logic signed [31:0]    coef_value,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_y,
	input  logic signed [31:0]    point_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    win_x,
	output logic signed [31:0]    win_y,
	output logic                  zero_w,
	output logic                  saturated
);

	logic signed [31:0] coef [STORE_DEPTH];
	viewport_t          vp;
	point_t             pt;
	logic               pt_valid, pt_pop, matrix_busy;

	vptw_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.coef       (coef),
		.vp         (vp),
		.pt         (pt),
		.pt_valid   (pt_valid),
		.pt_pop     (pt_pop),
		.matrix_busy(matrix_busy)
	);

	vptw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.coef       (coef),
		.vp         (vp),
		.pt         (pt),
		.pt_valid   (pt_valid),
		.pt_pop     (pt_pop),
		.matrix_busy(matrix_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.win_x      (win_x),
		.win_y      (win_y),
		.zero_w     (zero_w),
		.saturated  (saturated)
	);

endmodule

/* sv/vptw_fifo.sv */
module vptw_fifo #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		r = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
		return r;
	endfunction

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/vptw_front.sv */
module vptw_front import vptw_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  logic [4:0]            coef_index,
	input  logic signed [31:0]    coef_value,
	input  logic signed [31:0]    point_x,
	input  logic signed [31:0]    point_y,
	input  logic signed [31:0]    point_z,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic signed [31:0]    coef [STORE_DEPTH],
	output viewport_t             vp,
	output point_t                pt,
	output logic                  pt_valid,
	input  logic                  pt_pop,
	input  logic                  matrix_busy
);

	logic signed [31:0] coef_q [STORE_DEPTH];
	viewport_t          vp_q;
	logic               full, busy, take;
	point_t             pin;

	assign busy      = pt_valid || matrix_busy;
	assign in_ready  = (mode == MODE_PROJECT) ? !full : !busy;
	assign take      = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign pin       = '{x: point_x, y: point_y, z: point_z};
	assign coef      = coef_q;
	assign vp        = vp_q;

	// coefficients only change with the queue and the eye-space stages drained
	always_ff @(posedge clk) begin
		if (take && mode == MODE_LOAD) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_q <= '{left: 12'd0, bottom: 12'd0, span_x: 13'd640, span_y: 13'd480};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LEFT:   vp_q.left   <= cfg_data[11:0];
				CFG_BOTTOM: vp_q.bottom <= cfg_data[11:0];
				CFG_SPAN_X: vp_q.span_x <= cfg_data;
				CFG_SPAN_Y: vp_q.span_y <= cfg_data;
				default: ;
			endcase
		end
	end

	vptw_fifo #(
		.WIDTH($bits(point_t)),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && mode == MODE_PROJECT),
		.din      (pin),
		.full     (full),
		.pop      (pt_pop),
		.dout     (pt),
		.not_empty(pt_valid)
	);

endmodule

/* sv/vptw_divider.sv */
module vptw_divider #(
	parameter int N_BITS = 48,
	parameter int TAG_W  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [N_BITS-1:0] dividend,
	input  logic [31:0]       divisor,
	input  logic [TAG_W-1:0]  tag_in,
	output logic              out_valid,
	output logic [N_BITS-1:0] quotient,
	output logic [TAG_W-1:0]  tag_out
);

	// restoring division, one quotient bit per stage
	logic              vld_q [N_BITS];
	logic [31:0]       rem_q [N_BITS];
	logic [N_BITS-1:0] dq_q  [N_BITS];
	logic [31:0]       d_q   [N_BITS];
	logic [TAG_W-1:0]  tag_q [N_BITS];

	for (genvar k = 0; k < N_BITS; k++) begin : g_stg
		logic              v_i;
		logic [31:0]       rem_i, d_i;
		logic [N_BITS-1:0] dq_i;
		logic [TAG_W-1:0]  tag_i;
		logic [32:0]       t;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_i   = in_valid;
			assign rem_i = '0;
			assign dq_i  = dividend;
			assign d_i   = divisor;
			assign tag_i = tag_in;
		end else begin : g_next
			assign v_i   = vld_q[k-1];
			assign rem_i = rem_q[k-1];
			assign dq_i  = dq_q[k-1];
			assign d_i   = d_q[k-1];
			assign tag_i = tag_q[k-1];
		end

		assign t  = {rem_i, dq_i[N_BITS-1]};
		assign ge = (t >= {1'b0, d_i});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? 32'(t - {1'b0, d_i}) : t[31:0];
				dq_q[k]  <= {dq_i[N_BITS-2:0], ge};
				d_q[k]   <= d_i;
				tag_q[k] <= tag_i;
			end
		end
	end

	assign out_valid = vld_q[N_BITS-1];
	assign quotient  = dq_q[N_BITS-1];
	assign tag_out   = tag_q[N_BITS-1];

endmodule

/* sv/vptw_back.sv */
module vptw_back import vptw_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [31:0] coef [STORE_DEPTH],
	input  viewport_t          vp,
	input  point_t             pt,
	input  logic               pt_valid,
	output logic               pt_pop,
	output logic               matrix_busy,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] win_x,
	output logic signed [31:0] win_y,
	output logic               zero_w,
	output logic               saturated
);

	localparam int N = 32 + FRAC_BITS;
	localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [33:0] UNIT = 34'sd1 <<< FRAC_BITS;
	localparam logic [N-1:0] LIM_POS = N'(32'h7FFF_FFFF);

	function automatic logic [32:0] sat32(input logic signed [66:0] v);
		logic [32:0] r;
		if (v > 67'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -67'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic adv;
	logic out_valid_q;

	assign adv    = !out_valid_q || out_ready;
	assign pt_pop = pt_valid && adv;

	// eye space
	logic               v_s1, v_s2, v_s3;
	logic signed [63:0] prod_s1 [4][4];
	logic signed [65:0] sum_s2  [4];
	logic signed [31:0] eye_s3  [4];
	logic               sat_s3;
	logic signed [31:0] pv [3];
	logic [32:0]        eye_r [4];

	assign pv[0] = pt.x;
	assign pv[1] = pt.y;
	assign pv[2] = pt.z;
	assign matrix_busy = v_s1 || v_s2 || v_s3;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			eye_r[r] = sat32((67'(sum_s2[r]) + HALF) >>> FRAC_BITS);
		end
	end

	// clip space
	logic               v_s4, v_s5, v_s6;
	logic signed [63:0] prod_s4 [4][4];
	logic signed [65:0] sum_s5  [4];
	logic signed [31:0] clip_s6 [4];
	logic               sat_s4, sat_s5, sat_s6;
	logic [32:0]        clip_r [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			clip_r[r] = sat32((67'(sum_s5[r]) + HALF) >>> FRAC_BITS);
		end
	end

	// divider operands
	logic         v_s7, negx_s7, negy_s7, zw_s7, sat_s7;
	logic [N-1:0] dvdx_s7, dvdy_s7;
	logic [31:0]  d_s7;
	logic [31:0]  magx, magy, magw;

	assign magx = clip_s6[0][31] ? 32'(-clip_s6[0]) : clip_s6[0];
	assign magy = clip_s6[1][31] ? 32'(-clip_s6[1]) : clip_s6[1];
	assign magw = clip_s6[3][31] ? 32'(-clip_s6[3]) : clip_s6[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pt_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= coef[c*4 + r] * pv[c];
				end
				prod_s1[r][3] <= 64'(coef[12 + r]) <<< FRAC_BITS;
				sum_s2[r] <= 66'(prod_s1[r][0]) + 66'(prod_s1[r][1])
					+ 66'(prod_s1[r][2]) + 66'(prod_s1[r][3]);
				eye_s3[r] <= eye_r[r][31:0];
				for (int c = 0; c < 4; c++) begin
					prod_s4[r][c] <= coef[PROJ_BASE + c*4 + r] * eye_s3[c];
				end
				sum_s5[r] <= 66'(prod_s4[r][0]) + 66'(prod_s4[r][1])
					+ 66'(prod_s4[r][2]) + 66'(prod_s4[r][3]);
				clip_s6[r] <= clip_r[r][31:0];
			end
			sat_s3 <= eye_r[0][32] | eye_r[1][32] | eye_r[2][32] | eye_r[3][32];
			sat_s4 <= sat_s3;
			sat_s5 <= sat_s4;
			sat_s6 <= sat_s5 | clip_r[0][32] | clip_r[1][32] | clip_r[2][32]
				| clip_r[3][32];
			dvdx_s7 <= {magx, FRAC_BITS'(0)};
			dvdy_s7 <= {magy, FRAC_BITS'(0)};
			d_s7    <= magw;
			negx_s7 <= clip_s6[0][31] ^ clip_s6[3][31];
			negy_s7 <= clip_s6[1][31] ^ clip_s6[3][31];
			zw_s7   <= (clip_s6[3] == '0);
			sat_s7  <= sat_s6;
		end
	end

	logic         dv_x;
	logic [N-1:0] qx, qy;
	logic [2:0]   tag_x;
	logic         tag_y;

	vptw_divider #(.N_BITS(N), .TAG_W(3)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.dividend (dvdx_s7),
		.divisor  (d_s7),
		.tag_in   ({sat_s7, zw_s7, negx_s7}),
		.out_valid(dv_x),
		.quotient (qx),
		.tag_out  (tag_x)
	);

	vptw_divider #(.N_BITS(N), .TAG_W(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.dividend (dvdy_s7),
		.divisor  (d_s7),
		.tag_in   (negy_s7),
		.out_valid(),
		.quotient (qy),
		.tag_out  (tag_y)
	);

	// ndc clamp, viewport scale, offset
	logic               v_s8, v_s9;
	logic signed [31:0] ndcx_s8, ndcy_s8;
	logic               satm_s8, satn_s8, zw_s8;
	logic signed [47:0] px_s9, py_s9;
	logic               satm_s9, satn_s9, zw_s9;
	logic               sx, sy;
	logic signed [31:0] nx, ny;
	logic signed [33:0] ax, ay;
	logic signed [66:0] tx, ty;
	logic [32:0]        wx, wy;

	always_comb begin
		if (tag_x[0]) begin
			sx = (qx > LIM_POS + N'(1));
			nx = sx ? 32'sh8000_0000 : 32'(-qx[31:0]);
		end else begin
			sx = (qx > LIM_POS);
			nx = sx ? 32'sh7FFF_FFFF : qx[31:0];
		end
		if (tag_y) begin
			sy = (qy > LIM_POS + N'(1));
			ny = sy ? 32'sh8000_0000 : 32'(-qy[31:0]);
		end else begin
			sy = (qy > LIM_POS);
			ny = sy ? 32'sh7FFF_FFFF : qy[31:0];
		end
	end

	assign ax = 34'(ndcx_s8) + UNIT;
	assign ay = 34'(ndcy_s8) + UNIT;
	assign tx = (signed'(67'(vp.left)) <<< FRAC_BITS) + 67'(px_s9 >>> 1);
	assign ty = (signed'(67'(vp.bottom)) <<< FRAC_BITS) + 67'(py_s9 >>> 1);
	assign wx = sat32(tx);
	assign wy = sat32(ty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s8        <= dv_x;
			v_s9        <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ndcx_s8 <= nx;
			ndcy_s8 <= ny;
			satm_s8 <= tag_x[2];
			zw_s8   <= tag_x[1];
			satn_s8 <= sx | sy;
			px_s9   <= ax * signed'({1'b0, vp.span_x});
			py_s9   <= ay * signed'({1'b0, vp.span_y});
			satm_s9 <= satm_s8;
			satn_s9 <= satn_s8;
			zw_s9   <= zw_s8;
			win_x     <= zw_s9 ? '0 : wx[31:0];
			win_y     <= zw_s9 ? '0 : wy[31:0];
			zero_w    <= zw_s9;
			saturated <= satm_s9 | (!zw_s9 & (satn_s9 | wx[32] | wy[32]));
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* sv/vptw_checker.sv */
module vptw_checker import vptw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               mode,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] win_x,
	input logic signed [31:0] win_y,
	input logic               zero_w
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transaction dropped while stalled");

	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_w |-> win_x == '0 && win_y == '0)
		else $error("zero w with nonzero coordinates");

	a_load_order: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_PROJECT
		|=> !(in_valid && in_ready && mode == MODE_LOAD))
		else $error("load taken behind a pending point");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid straight out of reset");

endmodule

bind vertex_project_to_window_unit vptw_checker u_chk (.*);
